/* rtl/core/mtbl_pkg.sv */
`timescale 1ns / 1ps

package mtbl_pkg;

   // Field widths of the channels
   localparam int REQ_W    = 2;
   localparam int TOKEN_W  = 16;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;

   // Default table depth
   localparam int BUCKETS_DEF = 64;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FETCH   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RETRY   = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_WALK,
      S_FETCH,
      S_OUT
   } state_type;

   // One bucket as held in the table memory
   typedef struct packed {
      logic               valid;
      logic [TOKEN_W-1:0] tokens;
      logic [TOKEN_W-1:0] rate;
      logic [TOKEN_W-1:0] limit;
   } entry_type;

   // Outcome of the shared token unit
   typedef struct packed {
      logic               empty;
      logic [TOKEN_W-1:0] tokens;
      logic [TOKEN_W-1:0] give;
   } alu_res_type;

endpackage

/* rtl/core/mtbl_req_if.sv */
`timescale 1ns / 1ps

interface mtbl_req_if;
   logic                             valid;
   logic                             ready;
   logic [mtbl_pkg::REQ_W-1:0]       req_type;
   logic [mtbl_pkg::TOKEN_W-1:0]     rate_in;
   logic [mtbl_pkg::TOKEN_W-1:0]     limit_in;
   logic [mtbl_pkg::SLOT_W-1:0]      slot_in;
   logic [mtbl_pkg::TOKEN_W-1:0]     amount;

   modport source (
      output valid, req_type, rate_in, limit_in, slot_in, amount,
      input  ready
   );

   modport sink (
      input  valid, req_type, rate_in, limit_in, slot_in, amount,
      output ready
   );
endinterface

/* rtl/core/mtbl_rsp_if.sv */
`timescale 1ns / 1ps

interface mtbl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mtbl_pkg::STATUS_W-1:0]    status;
   logic [mtbl_pkg::SLOT_W-1:0]      slot_out;
   logic [mtbl_pkg::TOKEN_W-1:0]     granted;

   modport source (
      output valid, status, slot_out, granted,
      input  ready
   );

   modport sink (
      input  valid, status, slot_out, granted,
      output ready
   );
endinterface

/* rtl/core/mtbl_store.sv */
`timescale 1ns / 1ps

module mtbl_store #(
   parameter int BUCKETS = mtbl_pkg::BUCKETS_DEF,
   localparam int AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output mtbl_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  mtbl_pkg::entry_type wr_data
);

   mtbl_pkg::entry_type mem_ff [BUCKETS];
   mtbl_pkg::entry_type rd_data_ff;

   // Write one bucket
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one bucket, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mtbl_alu.sv */
`timescale 1ns / 1ps

module mtbl_alu (
   input  logic                          is_tick,
   input  mtbl_pkg::entry_type           entry,
   input  logic [mtbl_pkg::TOKEN_W-1:0]  amount,
   output mtbl_pkg::alu_res_type         res
);

   logic [mtbl_pkg::TOKEN_W:0]   sum;
   logic [mtbl_pkg::TOKEN_W-1:0] tick_tokens;
   logic [mtbl_pkg::TOKEN_W-1:0] give;

   // Refill: add the rate and clamp at the limit
   always_comb begin
      sum = {1'b0, entry.tokens} + {1'b0, entry.rate};
      if (sum >= {1'b0, entry.limit}) begin
         tick_tokens = entry.limit;
      end else begin
         tick_tokens = sum[mtbl_pkg::TOKEN_W-1:0];
      end
   end

   // Grant the smaller of request and tokens held
   assign give = (amount > entry.tokens) ? entry.tokens : amount;

   always_comb begin
      res.empty  = (entry.tokens == '0);
      res.give   = give;
      res.tokens = is_tick ? tick_tokens : (entry.tokens - give);
   end

endmodule

/* rtl/core/multi_token_bucket_limiter.sv */
`timescale 1ns / 1ps

// Table of BUCKETS token buckets behind a request channel and a response
// channel, both valid/ready; an item moves when valid and ready are high.
// Every request gives exactly one response item (status, slot, grant).
// One request is worked at a time; ready is high only while idle.
// The work per request is shaped by the single read port of the bucket
// memory and the one shared refill/grant unit: a destroy or a rejected
// fetch goes straight to the output stage; a fetch reads its bucket and
// then grants or refuses; a tick walks all buckets, one bucket a cycle;
// a create reads from slot 0 upward until it finds the lowest free slot.
// The response sits in an output register; the next request is accepted
// while it waits. A stalled receiver holds the response, and the next
// result then waits in the sequencer until the output register frees.
// After reset a clearing pass marks all BUCKETS entries free, one a cycle,
// so the first request is taken only once that pass is done.
module multi_token_bucket_limiter #(
   parameter int BUCKETS = mtbl_pkg::BUCKETS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mtbl_req_if.sink   req_chan,
   mtbl_rsp_if.source rsp_chan
);

   localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int CW = (AW + 1 > mtbl_pkg::SLOT_W + 1) ? AW + 1 : mtbl_pkg::SLOT_W + 1;
   localparam logic [AW-1:0] LAST = AW'(BUCKETS - 1);

   mtbl_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       tag_ff, tag_in;

   logic [mtbl_pkg::TOKEN_W-1:0] req_rate_ff, req_rate_in;
   logic [mtbl_pkg::TOKEN_W-1:0] req_limit_ff, req_limit_in;
   logic [mtbl_pkg::TOKEN_W-1:0] req_amount_ff, req_amount_in;

   logic [mtbl_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [mtbl_pkg::SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [mtbl_pkg::TOKEN_W-1:0]  res_granted_ff, res_granted_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mtbl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [mtbl_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [mtbl_pkg::TOKEN_W-1:0]  rsp_granted_ff, rsp_granted_in;

   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   mtbl_pkg::entry_type   rd_data;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   mtbl_pkg::entry_type   wr_data;
   mtbl_pkg::alu_res_type alu_res;

   logic          slot_ok;
   logic [AW-1:0] slot_addr;

   mtbl_store #(
      .BUCKETS (BUCKETS)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   mtbl_alu u_alu (
      .is_tick (state_ff == mtbl_pkg::S_WALK),
      .entry   (rd_data),
      .amount  (req_amount_ff),
      .res     (alu_res)
   );

   // Range check of the requested slot
   assign slot_ok   = CW'(req_chan.slot_in) < CW'(BUCKETS);
   assign slot_addr = AW'(req_chan.slot_in);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtbl_pkg::S_CLEAR;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_rate_ff    <= req_rate_in;
      req_limit_ff   <= req_limit_in;
      req_amount_ff  <= req_amount_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   // Sequencer: next state, memory access and results
   always_comb begin
      state_in       = state_ff;
      tag_in         = tag_ff;
      req_rate_in    = req_rate_ff;
      req_limit_in   = req_limit_ff;
      req_amount_in  = req_amount_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_granted_in = rsp_granted_ff;
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = AW'(tag_ff + 1'b1);
      wr_en          = 1'b0;
      wr_addr        = tag_ff;
      wr_data        = '{valid:  1'b0,
                         tokens: alu_res.tokens,
                         rate:   rd_data.rate,
                         limit:  rd_data.limit};

      case (state_ff)
         // Mark every entry free after reset
         mtbl_pkg::S_CLEAR: begin
            wr_en = 1'b1;
            if (tag_ff == LAST) begin
               tag_in   = '0;
               state_in = mtbl_pkg::S_IDLE;
            end else begin
               tag_in = AW'(tag_ff + 1'b1);
            end
         end

         // Take an item and start its work
         mtbl_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               req_rate_in   = req_chan.rate_in;
               req_limit_in  = req_chan.limit_in;
               req_amount_in = req_chan.amount;
               case (req_chan.req_type)
                  mtbl_pkg::REQ_CREATE: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     tag_in   = '0;
                     state_in = mtbl_pkg::S_SCAN;
                  end
                  mtbl_pkg::REQ_TICK: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     tag_in   = '0;
                     state_in = mtbl_pkg::S_WALK;
                  end
                  mtbl_pkg::REQ_FETCH: begin
                     if (!slot_ok || req_chan.amount == '0) begin
                        res_status_in  = mtbl_pkg::STATUS_INVALID;
                        res_slot_in    = '0;
                        res_granted_in = '0;
                        state_in       = mtbl_pkg::S_OUT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_addr;
                        tag_in   = slot_addr;
                        state_in = mtbl_pkg::S_FETCH;
                     end
                  end
                  mtbl_pkg::REQ_DESTROY: begin
                     if (!slot_ok) begin
                        res_status_in = mtbl_pkg::STATUS_INVALID;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = slot_addr;
                        res_status_in = mtbl_pkg::STATUS_OK;
                     end
                     res_slot_in    = '0;
                     res_granted_in = '0;
                     state_in       = mtbl_pkg::S_OUT;
                  end
                  default: begin
                     state_in = mtbl_pkg::S_IDLE;
                  end
               endcase
            end
         end

         // Look for the lowest free slot, one entry a cycle
         mtbl_pkg::S_SCAN: begin
            if (!rd_data.valid) begin
               wr_en          = 1'b1;
               wr_data        = '{valid:  1'b1,
                                  tokens: '0,
                                  rate:   req_rate_ff,
                                  limit:  req_limit_ff};
               res_status_in  = mtbl_pkg::STATUS_OK;
               res_slot_in    = mtbl_pkg::SLOT_W'(tag_ff);
               res_granted_in = '0;
               state_in       = mtbl_pkg::S_OUT;
            end else if (tag_ff == LAST) begin
               res_status_in  = mtbl_pkg::STATUS_NOSPACE;
               res_slot_in    = '0;
               res_granted_in = '0;
               state_in       = mtbl_pkg::S_OUT;
            end else begin
               rd_en  = 1'b1;
               tag_in = AW'(tag_ff + 1'b1);
            end
         end

         // Refill every valid bucket through the shared unit
         mtbl_pkg::S_WALK: begin
            wr_en         = rd_data.valid;
            wr_data.valid = 1'b1;
            if (tag_ff == LAST) begin
               res_status_in  = mtbl_pkg::STATUS_OK;
               res_slot_in    = '0;
               res_granted_in = '0;
               state_in       = mtbl_pkg::S_OUT;
            end else begin
               rd_en  = 1'b1;
               tag_in = AW'(tag_ff + 1'b1);
            end
         end

         // Grant from the addressed bucket
         mtbl_pkg::S_FETCH: begin
            res_slot_in    = '0;
            res_granted_in = '0;
            if (!rd_data.valid) begin
               res_status_in = mtbl_pkg::STATUS_INVALID;
            end else if (alu_res.empty) begin
               res_status_in = mtbl_pkg::STATUS_RETRY;
            end else begin
               wr_en          = 1'b1;
               wr_data.valid  = 1'b1;
               res_status_in  = mtbl_pkg::STATUS_OK;
               res_granted_in = alu_res.give;
            end
            state_in = mtbl_pkg::S_OUT;
         end

         // Hand the result to the output register once it is free
         mtbl_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_slot_in    = res_slot_ff;
               rsp_granted_in = res_granted_ff;
               state_in       = mtbl_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mtbl_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.slot_out = rsp_slot_ff;
   assign rsp_chan.granted  = rsp_granted_ff;

endmodule
